// ----- rtl/stm_pkg.sv -----
// Shared types and constants for the sparse triplet merge-add block.
package stm_pkg;

   // Commands carried in req_tuser
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_MERGE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // Configuration register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // Defaults for top-level parameters
   localparam int DEF_STORE_DEPTH = 32;
   localparam int DEF_COORD_BITS  = 8;

   // Fixed field widths
   localparam int IN_COORD_W = 8;
   localparam int IN_VAL_W   = 32;
   localparam int OUT_DIM_W  = 9;
   localparam int OUT_VAL_W  = 33;
   localparam int CNT_OUT_W  = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   localparam logic [OUT_DIM_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP
   } state_type;

endpackage

// ----- rtl/stm_store.sv -----
// Entry store for the first matrix: one write port, one registered read port.
module stm_store import stm_pkg::*; #(
   parameter int DEPTH  = DEF_STORE_DEPTH,
   parameter int IDX_W  = 5,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sparse_triplet_merge_add.sv -----
// Sparse matrix adder: merges two row-major sorted coordinate lists.
//
// Usage: load every entry of the first matrix with command LOAD (one transfer,
// one cycle each, no result). Then send each entry of the second matrix with
// command MERGE: the block first returns every stored entry whose (row, col)
// lies before it, then the entry itself, added to a stored entry with equal
// coordinates if there is one (sums that come out zero are still returned),
// with tlast on that final result. FINISH returns the remaining stored entries
// and then a header result (tuser high, tlast high) carrying the configured
// row and column counts and the number of entries emitted (saturating at 127);
// the job state then clears, the dimension registers are kept. A LOAD beyond
// the store depth is dropped and raises store_overflow on every result until
// the next FINISH. Command 3 is ignored. MERGE and FINISH are paced by the
// single registered read port of the entry store, each stored entry they
// flush passing through address, then data, then compare/add and write of
// the output register. The output register lets a result wait while the
// sequencer moves on; a stalled rsp side holds the sequencer in its compare
// step. Configuration writes apply at once and are meant for idle periods.
module sparse_triplet_merge_add import stm_pkg::*; #(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // in_row[7:0], in_col[15:8], in_value[47:16]
   input  logic [1:0]            req_tuser,  // command
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_row[8:0], out_col[17:9],
                                             // out_value[50:18], entry_count[57:51],
                                             // store_overflow[58], zero[63:59]
   output logic                  rsp_tuser,  // is_header
   output logic                  rsp_tlast,  // last result of the transfer's item
   // configuration
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [OUT_DIM_W-1:0]  csr_wdata
);

   // Coordinates kept after masking; the input fields are 8 bits wide
   localparam int CW     = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int ENT_W  = 2 * CW + IN_VAL_W;
   localparam logic [CNT_W-1:0]     DEPTH_C = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_OUT_W-1:0] CNT_MAX = '1;

   state_type state_ff, state_in;

   // latched request
   logic [1:0]          cmd_ff, cmd_in;
   logic [CW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [IN_VAL_W-1:0] val_ff, val_in;

   // job state
   logic [CNT_W-1:0]     cnt_ff, cnt_in;      // entries stored
   logic [CNT_W-1:0]     idx_ff, idx_in;      // next stored entry to merge
   logic [CNT_OUT_W-1:0] merged_ff, merged_in;
   logic                 ovf_ff, ovf_in;

   // configuration
   logic [OUT_DIM_W-1:0] rows_ff, cols_ff;

   // output register
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [OUT_DIM_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_DIM_W-1:0] rsp_col_ff, rsp_col_in;
   logic [OUT_VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_hdr_ff, rsp_hdr_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // store interface
   logic             wr_en;
   logic [ENT_W-1:0] rd_data;
   logic [CW-1:0]    st_row, st_col;
   logic [IN_VAL_W-1:0] st_val;

   // shared adder and key compare
   logic                 out_free, have, key_lt, key_eq, take_stored, hit;
   logic [OUT_VAL_W-1:0] add_a, add_b, sum;
   logic [CNT_OUT_W-1:0] merged_inc;

   stm_store #(
      .DEPTH  (STORE_DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (ENT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data ({req_tdata[16 +: IN_VAL_W], req_tdata[8 +: CW], req_tdata[0 +: CW]}),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign st_row = rd_data[0 +: CW];
   assign st_col = rd_data[CW +: CW];
   assign st_val = rd_data[2*CW +: IN_VAL_W];

   assign have   = (idx_ff < cnt_ff);
   assign key_lt = ({st_row, st_col} < {row_ff, col_ff});
   assign key_eq = ({st_row, st_col} == {row_ff, col_ff});
   // stored entry goes out alone: during FINISH, or when it sorts first
   assign take_stored = have && ((cmd_ff == CMD_FINISH) || key_lt);
   assign hit         = have && key_eq;

   assign add_a = take_stored ? '0 : {val_ff[IN_VAL_W-1], val_ff};
   assign add_b = (take_stored || hit) ? {st_val[IN_VAL_W-1], st_val} : '0;
   assign sum   = add_a + add_b;

   assign merged_inc = (merged_ff == CNT_MAX) ? merged_ff : merged_ff + 1'b1;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      merged_in   = merged_ff;
      ovf_in      = ovf_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_hdr_in  = rsp_hdr_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      req_tready  = 1'b0;
      wr_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in = req_tuser;
               row_in = req_tdata[0 +: CW];
               col_in = req_tdata[8 +: CW];
               val_in = req_tdata[16 +: IN_VAL_W];
               case (req_tuser)
                  CMD_LOAD: begin
                     if (cnt_ff < DEPTH_C) begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_MERGE, CMD_FINISH: state_in = ST_FETCH;
                  default: ;
               endcase
            end
         end

         ST_FETCH: state_in = ST_STEP;

         ST_STEP: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_ovf_in = ovf_ff;
               rsp_val_in = sum;
               rsp_cnt_in = '0;
               rsp_hdr_in = 1'b0;
               if (take_stored) begin
                  rsp_row_in  = OUT_DIM_W'(st_row);
                  rsp_col_in  = OUT_DIM_W'(st_col);
                  rsp_last_in = 1'b0;
                  idx_in      = idx_ff + 1'b1;
                  merged_in   = merged_inc;
                  state_in    = ST_FETCH;
               end else if (cmd_ff == CMD_FINISH) begin
                  // header, then clear the job
                  rsp_row_in  = rows_ff;
                  rsp_col_in  = cols_ff;
                  rsp_val_in  = '0;
                  rsp_cnt_in  = merged_ff;
                  rsp_hdr_in  = 1'b1;
                  rsp_last_in = 1'b1;
                  cnt_in      = '0;
                  idx_in      = '0;
                  merged_in   = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_row_in  = OUT_DIM_W'(row_ff);
                  rsp_col_in  = OUT_DIM_W'(col_ff);
                  rsp_last_in = 1'b1;
                  if (hit) begin
                     idx_in = idx_ff + 1'b1;
                  end
                  merged_in = merged_inc;
                  state_in  = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         idx_ff     <= '0;
         merged_ff  <= '0;
         ovf_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         merged_ff  <= merged_in;
         ovf_ff     <= ovf_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_hdr_ff  <= rsp_hdr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // dimension registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_ovf_ff, rsp_cnt_ff, rsp_val_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_hdr_ff;
   assign rsp_tlast  = rsp_last_ff;

   // read pointer never passes the fill count
   a_idx_le_cnt: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("merge pointer beyond stored entries");

   a_cnt_le_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("store fill count beyond depth");

   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("header result without tlast");

   // a FINISH step that writes the header leaves the job cleared
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && out_free && !take_stored && cmd_ff == CMD_FINISH)
      |=> (cnt_ff == '0 && idx_ff == '0 && merged_ff == '0 && !ovf_ff))
      else $error("job state not cleared after header");

endmodule

// ----- dv/tb_sparse_triplet_merge_add.sv -----
// Self-checking testbench for the sparse triplet merge-add block.
module tb_sparse_triplet_merge_add;
   import stm_pkg::*;

   localparam int STORE_SLOTS   = DEF_STORE_DEPTH;
   localparam int SETTLE_CYCLES = 16;      // trailing loads return nothing to wait for
   localparam int HOLD_CYCLES   = 300;     // long receiver stall, fills the block
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_PRINTS    = 40;
   localparam int COUNT_CEILING = 127;     // merged entry count saturates here
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One expected result transfer
   typedef struct {
      logic [OUT_DIM_W-1:0]        row;
      logic [OUT_DIM_W-1:0]        col;
      logic signed [OUT_VAL_W-1:0] value;
      logic [CNT_OUT_W-1:0]        count;
      logic                        overflow;
      logic                        header;
      logic                        last;
   } triplet_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // in_row[7:0], in_col[15:8], in_value[47:16]
   logic [1:0]            req_tuser  = CMD_LOAD;  // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // out_row[8:0], out_col[17:9], out_value[50:18],
                                      // entry_count[57:51], store_overflow[58], zero[63:59]
   logic                  rsp_tuser;  // is_header
   logic                  rsp_tlast;  // last result of the item
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CSR_ROWS;
   logic [OUT_DIM_W-1:0]  csr_wdata  = '0;

   // Predictor state: the first matrix as the block should hold it
   logic [IN_COORD_W-1:0]      store_row [STORE_SLOTS];
   logic [IN_COORD_W-1:0]      store_col [STORE_SLOTS];
   logic signed [IN_VAL_W-1:0] store_val [STORE_SLOTS];
   int unsigned                stored_n;
   int unsigned                read_ptr;
   int unsigned                merged_n;
   logic                       overflow_seen = 1'b0;
   logic [OUT_DIM_W-1:0]       dim_rows = DIM_RESET;
   logic [OUT_DIM_W-1:0]       dim_cols = DIM_RESET;

   triplet_t due_triplets[$];   // results owed by the block, oldest first

   int req_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   int results_seen;
   int mismatches;
   int cycle_count;
   int hold_requests;           // bumped by the test sequence
   int hold_served;             // owned by the ready pacing process
   int hold_left;

   sparse_triplet_merge_add uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops results
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_triplets.size());
         $display("FAILURE");
         $finish;
      end
   end

   //--------------------------------------------------------------------------
   // Predictor
   //--------------------------------------------------------------------------

   // Queue one expected result; the overflow flag rides on every result.
   function automatic void push_result(input logic [OUT_DIM_W-1:0] row,
                                       input logic [OUT_DIM_W-1:0] col,
                                       input logic signed [OUT_VAL_W-1:0] value,
                                       input logic [CNT_OUT_W-1:0] count,
                                       input logic header,
                                       input logic last);
      triplet_t t;
      t.row      = row;
      t.col      = col;
      t.value    = value;
      t.count    = count;
      t.overflow = overflow_seen;
      t.header   = header;
      t.last     = last;
      due_triplets.push_back(t);
   endfunction

   function automatic void bump_merged();
      if (merged_n < COUNT_CEILING) merged_n++;
   endfunction

   // Pass the next stored first-matrix entry through unchanged.
   function automatic void flush_stored();
      push_result(OUT_DIM_W'(store_row[read_ptr]), OUT_DIM_W'(store_col[read_ptr]),
                  OUT_VAL_W'(store_val[read_ptr]), '0, 1'b0, 1'b0);
      read_ptr++;
      bump_merged();
   endfunction

   // Work out every result one accepted item causes.
   function automatic void merge_add_predict(input logic [1:0] cmd,
                                             input logic [IN_COORD_W-1:0] row,
                                             input logic [IN_COORD_W-1:0] col,
                                             input logic signed [IN_VAL_W-1:0] val);
      logic [2*IN_COORD_W-1:0]     key;
      logic signed [OUT_VAL_W-1:0] sum;
      key = {row, col};
      sum = OUT_VAL_W'(val);
      case (cmd)
         CMD_LOAD: begin
            if (stored_n < STORE_SLOTS) begin
               store_row[stored_n] = row;
               store_col[stored_n] = col;
               store_val[stored_n] = val;
               stored_n++;
            end else begin
               overflow_seen = 1'b1;   // store full: entry dropped
            end
         end
         CMD_MERGE: begin
            // stored entries ahead of this key go out first
            while (read_ptr < stored_n && {store_row[read_ptr], store_col[read_ptr]} < key)
               flush_stored();
            // a stored entry at the same coordinates is folded into the sum
            if (read_ptr < stored_n && {store_row[read_ptr], store_col[read_ptr]} == key) begin
               sum = sum + OUT_VAL_W'(store_val[read_ptr]);
               read_ptr++;
            end
            push_result(OUT_DIM_W'(row), OUT_DIM_W'(col), sum, '0, 1'b0, 1'b1);
            bump_merged();
         end
         CMD_FINISH: begin
            while (read_ptr < stored_n) flush_stored();
            push_result(dim_rows, dim_cols, '0, CNT_OUT_W'(merged_n), 1'b1, 1'b1);
            stored_n      = 0;
            read_ptr      = 0;
            merged_n      = 0;
            overflow_seen = 1'b0;
         end
         default: ;   // unused command: no effect
      endcase
   endfunction

   //--------------------------------------------------------------------------
   // Result side: ready pacing and checking
   //--------------------------------------------------------------------------

   // Random ready; a hold request forces a long stretch of ready low.
   always @(posedge clock) begin : rsp_pacing
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic note_mismatch(input string msg);
      if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         note_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 results_seen, name, got, want));
   endtask

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin : result_check
      triplet_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_triplets.size() == 0) begin
            note_mismatch($sformatf("result %0d with nothing expected: data 0x%h",
                                    results_seen, rsp_tdata));
         end else begin
            want = due_triplets.pop_front();
            check_field("row",      rsp_tdata[8:0],   want.row);
            check_field("col",      rsp_tdata[17:9],  want.col);
            check_field("value",    rsp_tdata[50:18], $unsigned(want.value));
            check_field("count",    rsp_tdata[57:51], want.count);
            check_field("overflow", rsp_tdata[58],    want.overflow);
            check_field("padding",  rsp_tdata[63:59], '0);
            check_field("header",   rsp_tuser,        want.header);
            check_field("last",     rsp_tlast,        want.last);
         end
         results_seen++;
      end
   end

   //--------------------------------------------------------------------------
   // Stimulus helpers
   //--------------------------------------------------------------------------

   function automatic logic [31:0] rand_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_key();
      return 16'($urandom);
   endfunction

   // Offer one item and hold it until the transfer happens. Valid stays high
   // into the next call unless that call starts with an idle gap.
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] key,
                            input logic [31:0] val);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {val, key[7:0], key[15:8]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      merge_add_predict(cmd, key[15:8], key[7:0], val);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Drop valid, let every owed result come back, then allow trailing loads
   // to finish before anything touches the registers.
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_triplets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [OUT_DIM_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_ROWS) dim_rows = value;
      else dim_cols = value;
      @(posedge clock);
   endtask

   // Stray items that break an otherwise sorted job.
   task automatic send_noise();
      case ($urandom_range(2))
         0:       send_item(CMD_UNUSED, rand_key(), rand_value());
         1:       send_item(CMD_LOAD,   rand_key(), rand_value());  // load after merging began
         default: send_item(CMD_MERGE,  rand_key(), rand_value());  // out-of-order key
      endcase
   endtask

   // One job: sorted loads, sorted merges with occasional noise, finish. Walking
   // one cursor for both lists makes shared coordinates, which exercise the adder.
   task automatic run_job(input int steps, input int span);
      logic [15:0] load_keys[$];
      logic [15:0] merge_keys[$];
      int          cursor;
      cursor = $urandom_range(0, span);
      for (int i = 0; i < steps; i++) begin
         cursor += $urandom_range(1, span);
         if (cursor > 16'hFFFF) break;
         case ($urandom_range(2))
            0: load_keys.push_back(cursor[15:0]);
            1: merge_keys.push_back(cursor[15:0]);
            default: begin
               load_keys.push_back(cursor[15:0]);
               merge_keys.push_back(cursor[15:0]);
            end
         endcase
      end
      foreach (load_keys[i]) send_item(CMD_LOAD, load_keys[i], rand_value());
      foreach (merge_keys[i]) begin
         send_item(CMD_MERGE, merge_keys[i], rand_value());
         if ($urandom_range(24) == 0) send_noise();
      end
      send_item(CMD_FINISH, rand_key(), rand_value());
   endtask

   task automatic run_random_job();
      int steps;
      int span;
      case ($urandom_range(2))
         0:       span = 3;      // packed into one row
         1:       span = 256;
         default: span = 4000;   // spread over the whole key range
      endcase
      case ($urandom_range(11))
         0:       begin steps = $urandom_range(60, 70); span = 100; end  // overruns the store
         1:       steps = 0;                                             // finish only
         default: steps = $urandom_range(1, 16);
      endcase
      run_job(steps, span);
   endtask

   //--------------------------------------------------------------------------
   // Tests
   //--------------------------------------------------------------------------

   // Hand-picked items: reset dimensions, empty store, extreme sums, a sum
   // of zero, the unused command, a late load and an out-of-order merge.
   task automatic test_directed();
      send_item(CMD_FINISH, 16'h0000, 32'h0);                  // header right after reset
      send_item(CMD_MERGE,  16'hFFFF, 32'h1);                  // nothing stored yet
      send_item(CMD_FINISH, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(CMD_LOAD,   {8'd0,   8'd0},   32'h8000_0000);
      send_item(CMD_LOAD,   {8'd0,   8'd7},   32'd5);
      send_item(CMD_LOAD,   {8'd17,  8'd200}, 32'hFFFF_FFF9);
      send_item(CMD_LOAD,   {8'd255, 8'd255}, 32'h7FFF_FFFF);
      send_item(CMD_UNUSED, 16'h5AA5, 32'hA5A5_5A5A);         // ignored
      send_item(CMD_MERGE,  {8'd0,   8'd0},   32'h8000_0000); // most negative sum
      send_item(CMD_MERGE,  {8'd17,  8'd200}, 32'd7);         // flushes one, sums to zero
      send_item(CMD_LOAD,   {8'd255, 8'd0},   32'd9);         // appended mid-merge
      send_item(CMD_MERGE,  {8'd100, 8'd100}, 32'hFFFF_FFFF);
      send_item(CMD_MERGE,  {8'd255, 8'd255}, 32'h7FFF_FFFF); // largest sum
      send_item(CMD_MERGE,  {8'd10,  8'd10},  32'd3);         // key behind the stream
      send_item(CMD_FINISH, 16'h0000, 32'h0);                  // flushes the late load
      send_item(CMD_MERGE,  {8'd255, 8'd0},   32'h0);
      send_item(CMD_FINISH, 16'hA5A5, 32'h5A5A_A5A5);
   endtask

   // Dimension registers at their extremes and in between, each checked
   // through the header of a short job.
   task automatic test_dimension_registers();
      logic [OUT_DIM_W-1:0] rows;
      logic [OUT_DIM_W-1:0] cols;
      for (int k = 0; k < 5; k++) begin
         case (k)
            0:       begin rows = 9'd0;   cols = 9'd0;   end
            1:       begin rows = 9'd256; cols = 9'd256; end
            2:       begin rows = 9'd255; cols = 9'd1;   end
            3:       begin rows = 9'd1;   cols = 9'd255; end
            default: begin
               rows = 9'($urandom_range(256));
               cols = 9'($urandom_range(256));
            end
         endcase
         wait_block_idle();
         write_csr(CSR_ROWS, rows);
         write_csr(CSR_COLS, cols);
         run_job(4, 2000);
      end
   endtask

   // Overrun the store, then emit enough entries to saturate the count.
   // Loads sit on even rows and merges on odd rows, so nothing is summed.
   task automatic test_overflow_and_count_limit();
      for (int i = 0; i < STORE_SLOTS + 2; i++)
         send_item(CMD_LOAD, {8'(2 * i), 8'($urandom)}, rand_value());
      send_item(CMD_UNUSED, rand_key(), rand_value());
      for (int i = 0; i < 100; i++)
         send_item(CMD_MERGE, {8'(2 * i + 1), 8'($urandom)}, rand_value());
      send_item(CMD_FINISH, rand_key(), rand_value());
      run_job(6, 300);   // flag and count must be clear again
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                      input int target);
      int start;
      wait_block_idle();
      write_csr(CSR_ROWS, 9'($urandom_range(256)));
      write_csr(CSR_COLS, 9'($urandom_range(256)));
      req_idle_pct = sender_idle;
      rsp_idle_pct = receiver_idle;
      start = items_sent;
      while (items_sent - start < target) run_random_job();
   endtask

   // Receiver stalls for a long stretch while items keep coming, so the
   // output register fills and the block has to hold off its input.
   task automatic test_result_stall();
      wait_block_idle();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests++;
      run_job(16, 300);
   endtask

   initial begin : main_sequence
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 14;
      rsp_idle_pct = 45;
      test_directed();
      test_dimension_registers();
      test_random_traffic(14, 45, 15);

      req_idle_pct = 45;
      rsp_idle_pct = 14;
      test_overflow_and_count_limit();
      test_random_traffic(45, 14, 15);

      test_random_traffic(0, 0, 15);
      test_result_stall();

      wait_block_idle();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
